>>> hw/rtl/ohtab_pkg.sv
// ----------------------------------------------------------------------------
// ohtab_pkg
// Shared types and constants of the open-addressing hash table.
// ----------------------------------------------------------------------------
package ohtab_pkg;

	localparam int SLOTS_DEF      = 1024;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;

	localparam int KIND_W  = 3;
	localparam int HASH_W  = 32;
	localparam int WORD_W  = 32;
	localparam int LIVE_W  = 11;

	localparam logic [KIND_W-1:0] KIND_GET    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SET    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

	localparam logic [1:0] MARK_EMPTY = 2'd0;
	localparam logic [1:0] MARK_LIVE  = 2'd1;
	localparam logic [1:0] MARK_TOMB  = 2'd2;

	typedef enum logic [2:0] {
		OP_GET,
		OP_INSERT,
		OP_SET,
		OP_POP,
		OP_CLEAR,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [HASH_W-1:0] hash;
		logic [WORD_W-1:0] key;
		logic [WORD_W-1:0] value;
	} req_t;

endpackage

>>> hw/rtl/ohtab_ram.sv
// ----------------------------------------------------------------------------
// ohtab_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ohtab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/ohtab_front.sv
// ----------------------------------------------------------------------------
// ohtab_front
// Accept requests, decode the kind and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module ohtab_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [ohtab_pkg::KIND_W-1:0]    kind,
	input  logic [ohtab_pkg::HASH_W-1:0]    key_hash,
	input  logic [ohtab_pkg::WORD_W-1:0]    key,
	input  logic [ohtab_pkg::WORD_W-1:0]    new_value,
	output logic                            req_valid,
	output ohtab_pkg::req_t                 req,
	input  logic                            req_take
);

	ohtab_pkg::req_t  entry_q [2];
	ohtab_pkg::req_t  in_req;
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_take;

	always_comb begin
		unique case (kind)
			ohtab_pkg::KIND_GET:    in_req.op = ohtab_pkg::OP_GET;
			ohtab_pkg::KIND_INSERT: in_req.op = ohtab_pkg::OP_INSERT;
			ohtab_pkg::KIND_SET:    in_req.op = ohtab_pkg::OP_SET;
			ohtab_pkg::KIND_POP:    in_req.op = ohtab_pkg::OP_POP;
			ohtab_pkg::KIND_CLEAR:  in_req.op = ohtab_pkg::OP_CLEAR;
			default:                in_req.op = ohtab_pkg::OP_NONE;
		endcase
		in_req.hash  = key_hash;
		in_req.key   = key;
		in_req.value = new_value;
	end

	assign full      = (count_q == 2'd2);
	assign req_valid = (count_q != 2'd0);
	assign req       = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_take   = req_take && req_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_take) begin
				count_q <= count_q + 2'd1;
			end else if (do_take && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> hw/rtl/ohtab_back.sv
// ----------------------------------------------------------------------------
// ohtab_back
// Probe or sweep the slot memory for one request at a time, update it, post a result.
// ----------------------------------------------------------------------------
module ohtab_back #(
	parameter int SLOTS      = ohtab_pkg::SLOTS_DEF,
	parameter int KEY_BITS   = ohtab_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = ohtab_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  ohtab_pkg::req_t               req,
	output logic                          req_take,
	output logic                          empty,
	input  logic                          pop,
	output logic                          was_present,
	output logic [ohtab_pkg::WORD_W-1:0]  old_value,
	output logic                          status,
	output logic [ohtab_pkg::LIVE_W-1:0]  live_count
);

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int CNT_W  = IDX_W + 1;
	localparam int H_W    = ohtab_pkg::HASH_W;
	localparam int ROW_W  = 2 + H_W + KEY_BITS + VALUE_BITS;
	localparam int V_LO   = 0;
	localparam int K_LO   = VALUE_BITS;
	localparam int H_LO   = VALUE_BITS + KEY_BITS;
	localparam int M_LO   = H_LO + H_W;
	localparam int LIMIT  = (SLOTS - 1) - ((SLOTS - 1) >> 2);

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_PROBE
	} state_t;

	state_t                  state_q;
	logic [IDX_W-1:0]        sweep_q;
	logic                    sweep_res_q;
	logic [IDX_W-1:0]        pos_q;
	logic [IDX_W-1:0]        step_q;
	logic [CNT_W-1:0]        n_q;
	logic                    have_free_q;
	logic [IDX_W-1:0]        free_q;
	ohtab_pkg::op_t          op_q;
	logic [H_W-1:0]          hash_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [VALUE_BITS-1:0]   val_q;
	logic [CNT_W-1:0]        live_q;
	logic [CNT_W-1:0]        filled_q;
	logic                    out_valid_q;
	logic                    present_q;
	logic [ohtab_pkg::WORD_W-1:0] old_q;
	logic                    status_q;
	logic [ohtab_pkg::LIVE_W-1:0] live_out_q;

	logic                    ram_we;
	logic [IDX_W-1:0]        ram_waddr;
	logic [ROW_W-1:0]        ram_wdata;
	logic [IDX_W-1:0]        ram_raddr;
	logic [ROW_W-1:0]        ram_rdata;

	logic [1:0]              rd_mark;
	logic [H_W-1:0]          rd_hash;
	logic [KEY_BITS-1:0]     rd_key;
	logic [VALUE_BITS-1:0]   rd_val;
	logic                    is_empty, is_tomb, is_hit, is_last, probe_done;
	logic                    have_slot, grows, refuse, is_write_op;
	logic [IDX_W-1:0]        tgt_slot;
	logic [CNT_W-1:0]        live_nxt, filled_nxt;
	logic [63:0]             key_ext, val_ext, old_ext;
	logic                    out_free;

	ohtab_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_mark = ram_rdata[M_LO +: 2];
	assign rd_hash = ram_rdata[H_LO +: H_W];
	assign rd_key  = ram_rdata[K_LO +: KEY_BITS];
	assign rd_val  = ram_rdata[V_LO +: VALUE_BITS];

	assign key_ext = {32'd0, req.key};
	assign val_ext = {32'd0, req.value};
	assign old_ext = 64'(rd_val);

	assign out_free = !out_valid_q || pop;
	assign req_take = (state_q == ST_IDLE) && req_valid && out_free;

	// Probe step evaluation
	always_comb begin
		is_empty    = (rd_mark == ohtab_pkg::MARK_EMPTY);
		is_tomb     = (rd_mark == ohtab_pkg::MARK_TOMB);
		is_hit      = (rd_mark == ohtab_pkg::MARK_LIVE) && (rd_hash == hash_q)
		              && (rd_key == key_q);
		is_last     = (n_q == CNT_W'(SLOTS - 1));
		probe_done  = is_empty || is_hit || is_last;
		have_slot   = is_empty || have_free_q || is_tomb;
		tgt_slot    = have_free_q ? free_q : pos_q;
		grows       = is_empty && !have_free_q;
		refuse      = !have_slot || (grows && (filled_q >= CNT_W'(LIMIT)));
		is_write_op = (op_q == ohtab_pkg::OP_INSERT) || (op_q == ohtab_pkg::OP_SET);
		live_nxt    = live_q;
		filled_nxt  = filled_q;
		ram_we      = 1'b0;
		ram_waddr   = pos_q;
		ram_wdata   = {ohtab_pkg::MARK_LIVE, rd_hash, rd_key, val_q};
		unique case (state_q)
			ST_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
				ram_wdata = {ohtab_pkg::MARK_EMPTY, (ROW_W - 2)'(0)};
			end
			ST_PROBE: begin
				if (is_hit) begin
					if (op_q == ohtab_pkg::OP_SET) begin
						ram_we = 1'b1;
					end else if (op_q == ohtab_pkg::OP_POP) begin
						ram_we    = 1'b1;
						ram_wdata = {ohtab_pkg::MARK_TOMB, rd_hash, rd_key, rd_val};
						live_nxt  = live_q - CNT_W'(1);
					end
				end else if (probe_done && is_write_op && !refuse) begin
					ram_we    = 1'b1;
					ram_waddr = tgt_slot;
					ram_wdata = {ohtab_pkg::MARK_LIVE, hash_q, key_q, val_q};
					live_nxt  = live_q + CNT_W'(1);
					if (grows) begin
						filled_nxt = filled_q + CNT_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Read the first slot on taking a request, then the next one in each probe step
	assign ram_raddr = (state_q == ST_PROBE) ? pos_q + step_q : req.hash[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			sweep_q     <= '0;
			sweep_res_q <= 1'b0;
			pos_q       <= '0;
			step_q      <= '0;
			n_q         <= '0;
			have_free_q <= 1'b0;
			free_q      <= '0;
			op_q        <= ohtab_pkg::OP_NONE;
			hash_q      <= '0;
			key_q       <= '0;
			val_q       <= '0;
			live_q      <= '0;
			filled_q    <= '0;
			out_valid_q <= 1'b0;
			present_q   <= 1'b0;
			old_q       <= '0;
			status_q    <= 1'b0;
			live_out_q  <= '0;
		end else begin
			if (out_valid_q && pop && !(req_take && (req.op == ohtab_pkg::OP_NONE))) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_SWEEP: begin
					sweep_q <= sweep_q + IDX_W'(1);
					if (sweep_q == IDX_W'(SLOTS - 1)) begin
						state_q     <= ST_IDLE;
						sweep_res_q <= 1'b0;
						if (sweep_res_q) begin
							out_valid_q <= 1'b1;
							present_q   <= 1'b0;
							old_q       <= '0;
							status_q    <= 1'b0;
							live_out_q  <= '0;
						end
					end
				end
				ST_IDLE: begin
					if (req_take) begin
						op_q        <= req.op;
						hash_q      <= req.hash;
						key_q       <= key_ext[KEY_BITS-1:0];
						val_q       <= val_ext[VALUE_BITS-1:0];
						pos_q       <= req.hash[IDX_W-1:0];
						step_q      <= IDX_W'(1);
						n_q         <= '0;
						have_free_q <= 1'b0;
						priority case (req.op)
							ohtab_pkg::OP_CLEAR: begin
								state_q     <= ST_SWEEP;
								sweep_q     <= '0;
								sweep_res_q <= 1'b1;
								live_q      <= '0;
								filled_q    <= '0;
							end
							ohtab_pkg::OP_NONE: begin
								out_valid_q <= 1'b1;
								present_q   <= 1'b0;
								old_q       <= '0;
								status_q    <= 1'b0;
								live_out_q  <= ohtab_pkg::LIVE_W'(live_q);
							end
							default: begin
								state_q <= ST_PROBE;
							end
						endcase
					end
				end
				ST_PROBE: begin
					if (probe_done) begin
						state_q     <= ST_IDLE;
						live_q      <= live_nxt;
						filled_q    <= filled_nxt;
						out_valid_q <= 1'b1;
						present_q   <= is_hit;
						old_q       <= is_hit ? old_ext[ohtab_pkg::WORD_W-1:0] : '0;
						status_q    <= !is_hit && is_write_op && refuse;
						live_out_q  <= ohtab_pkg::LIVE_W'(live_nxt);
					end else begin
						// Advance by the triangular step, remember the first tombstone
						pos_q  <= pos_q + step_q;
						step_q <= step_q + IDX_W'(1);
						n_q    <= n_q + CNT_W'(1);
						if (is_tomb && !have_free_q) begin
							have_free_q <= 1'b1;
							free_q      <= pos_q;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign empty       = !out_valid_q;
	assign was_present = present_q;
	assign old_value   = old_q;
	assign status      = status_q;
	assign live_count  = live_out_q;

endmodule

>>> hw/rtl/open_addressing_hash_table.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Fixed-capacity hash table with triangular probing over one slot memory.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake         Payload
//  -------   ---------------   ---------------------------------------------
//  request   push / full       kind, key_hash, key, new_value
//  result    empty / pop       was_present, old_value, status, live_count
//
//  A get, insert, set or pop probes slots in the back end one after another,
//  one slot read per cycle through the memory's read port; a clear sweeps
//  every slot before posting its result, and an unused kind posts a result
//  without probing. After reset every slot is swept to empty; requests are
//  queued meanwhile but not carried out.
//  A two-entry queue accepts requests until full while the back end probes or
//  a result awaits popping; the back end holds while its result is unpopped.
//
module open_addressing_hash_table #(
	parameter int SLOTS      = ohtab_pkg::SLOTS_DEF,
	parameter int KEY_BITS   = ohtab_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = ohtab_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [ohtab_pkg::KIND_W-1:0]  kind,
	input  logic [ohtab_pkg::HASH_W-1:0]  key_hash,
	input  logic [ohtab_pkg::WORD_W-1:0]  key,
	input  logic [ohtab_pkg::WORD_W-1:0]  new_value,
	output logic                          empty,
	input  logic                          pop,
	output logic                          was_present,
	output logic [ohtab_pkg::WORD_W-1:0]  old_value,
	output logic                          status,
	output logic [ohtab_pkg::LIVE_W-1:0]  live_count
);

	// Decoded request handed from the front queue to the back end
	logic            req_valid;
	ohtab_pkg::req_t req;
	logic            req_take;

	// Front: accept each transfer, decode the kind, queue it
	ohtab_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.key_hash  (key_hash),
		.key       (key),
		.new_value (new_value),
		.req_valid (req_valid),
		.req       (req),
		.req_take  (req_take)
	);

	// Back: probe, update the slots and counts, hold the result for popping
	ohtab_back #(
		.SLOTS      (SLOTS),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req         (req),
		.req_take    (req_take),
		.empty       (empty),
		.pop         (pop),
		.was_present (was_present),
		.old_value   (old_value),
		.status      (status),
		.live_count  (live_count)
	);

endmodule
